FILE: rtl/mmp_pkg.sv
// -----------------------------------------------------------------------------
// mmp_pkg
// Shared constants, request codes and the request bundle of the matrix power
// block.
// -----------------------------------------------------------------------------
package mmp_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int VAL_W = 30;
  localparam int ROW_W = 3;
  localparam int EXP_W = 63;
  localparam int REQ_W = 2;
  localparam int SIZE_W = 4;

  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 32;

  localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
  localparam logic [VAL_W:0] MODULUS_X2 = 31'd2000000014;
  // floor(2^60 / modulus) for the Barrett estimate
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RUN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  typedef struct packed {
    logic wr;
    logic rd;
    logic run;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [EXP_W-1:0] exponent;
  } mmp_req_t;

endpackage

FILE: rtl/mmp_modmul.sv
// -----------------------------------------------------------------------------
// mmp_modmul
// Five-stage modular multiplier: product, Barrett estimate, quotient times
// modulus, remainder, final correction. Carries a tag alongside each operand.
// -----------------------------------------------------------------------------
module mmp_modmul import mmp_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [TAG_W-1:0] in_tag,
  input  logic [VAL_W-1:0] in_a,
  input  logic [VAL_W-1:0] in_b,
  output logic             out_valid,
  output logic [TAG_W-1:0] out_tag,
  output logic [VAL_W-1:0] out_res
);

  logic [4:0]       v_r;
  logic [TAG_W-1:0] tag_r [5];
  logic [59:0]      prod_r;
  logic [61:0]      est_r;
  logic [32:0]      x2_r;
  logic [32:0]      x3_r;
  logic [32:0]      qp_r;
  logic [31:0]      rem_r;
  logic [VAL_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int s = 1; s < 5; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    prod_r <= 60'(in_a) * 60'(in_b);
    est_r  <= 62'(prod_r[59:29]) * 62'(BARRETT_MU);
    x2_r   <= prod_r[32:0];
    qp_r   <= 33'(61'(est_r[61:31]) * 61'(MODULUS));
    x3_r   <= x2_r;
    // remainder is below three moduli, so the low bits suffice
    rem_r  <= 32'(x3_r - qp_r);
    if (rem_r >= 32'(MODULUS_X2)) begin
      res_r <= VAL_W'(rem_r - 32'(MODULUS_X2));
    end else if (rem_r >= 32'(MODULUS)) begin
      res_r <= VAL_W'(rem_r - 32'(MODULUS));
    end else begin
      res_r <= VAL_W'(rem_r);
    end
  end

  assign out_valid = v_r[4];
  assign out_tag   = tag_r[4];
  assign out_res   = res_r;

endmodule

FILE: rtl/mmp_core.sv
// -----------------------------------------------------------------------------
// mmp_core
// Matrix stores and run sequencer: clear pass, load, multiply passes through
// the modular multiplier into a scratch store, and copy-back sweeps.
// -----------------------------------------------------------------------------
module mmp_core import mmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mmp_req_t                         req,
  input  logic [$clog2(MAX_DIM+1)-1:0]     dim,
  output logic                             busy,
  output logic [VAL_W-1:0]                 rdata
);

  localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DMW = $clog2(MAX_DIM + 1);
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int TAG_W = CW + 3;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_INIT, ST_NEXT, ST_MUL, ST_MWAIT, ST_COPY
  } state_t;

  typedef struct packed {
    logic          fin;
    logic          last;
    logic          first;
    logic [CW-1:0] dest;
  } mtag_t;

  function automatic logic [CW-1:0] cell_addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
    return CW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  state_t           state_r;
  logic [DW-1:0]    i_r, j_r, k_r;
  logic [DMW-1:0]   dim_r;
  logic [EXP_W-1:0] exp_r;
  logic             stepped_r;
  logic             sq_r;

  logic [VAL_W-1:0] base_mem [CELLS];
  logic [VAL_W-1:0] sq_mem   [CELLS];
  logic [VAL_W-1:0] res_mem  [CELLS];
  logic [VAL_W-1:0] prd_mem  [CELLS];

  logic [VAL_W-1:0] base_rd_r, sqa_rd_r, sqb_rd_r, res_rd_r, prd_rd_r;

  logic             init_v_r, mt_v_r, cp_v_r;
  logic [CW-1:0]    init_addr_r, cp_addr_r;
  mtag_t            mt_tag_r;
  logic [VAL_W-1:0] acc_r;

  logic [DMW-1:0]   lim;
  logic             end_i, end_j, end_k;
  logic [CW-1:0]    cur, x_addr, y_addr, req_addr;
  mtag_t            mt_tag;

  logic             mm_v;
  logic [TAG_W-1:0] mm_tag_bits;
  mtag_t            mm_tag;
  logic [VAL_W-1:0] mm_res;
  logic [VAL_W:0]   acc_sum;
  logic [VAL_W-1:0] acc_red;
  logic             acc_fin;

  logic             base_we, res_we, sq_we, prd_we, res_re;
  logic [CW-1:0]    base_waddr, res_waddr, sq_waddr, res_raddr;
  logic [VAL_W-1:0] base_wdata, res_wdata, sq_wdata;

  always_comb begin
    if (state_r == ST_CLEAR || state_r == ST_INIT) begin
      lim = DMW'(MAX_DIM - 1);
    end else begin
      lim = dim_r - 1'b1;
    end
    end_i    = (DMW'(i_r) == lim);
    end_j    = (DMW'(j_r) == lim);
    end_k    = (DMW'(k_r) == lim);
    cur      = cell_addr(i_r, j_r);
    x_addr   = cell_addr(i_r, k_r);
    y_addr   = cell_addr(k_r, j_r);
    req_addr = CW'(int'(req.row) * MAX_DIM + int'(req.col));
    mt_tag.fin   = end_i && end_j && end_k;
    mt_tag.last  = end_k;
    mt_tag.first = (k_r == '0);
    mt_tag.dest  = cur;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      dim_r     <= DMW'(1);
      exp_r     <= '0;
      stepped_r <= 1'b0;
      sq_r      <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR, ST_INIT: begin
          if (end_j) begin
            j_r <= '0;
            if (end_i) begin
              i_r       <= '0;
              stepped_r <= 1'b0;
              state_r   <= (state_r == ST_CLEAR) ? ST_IDLE : ST_NEXT;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req.run) begin
            dim_r   <= dim;
            exp_r   <= req.exponent;
            state_r <= ST_INIT;
          end
        end
        ST_NEXT: begin
          if (exp_r == '0) begin
            state_r <= ST_IDLE;
          end else if (exp_r[0] && !stepped_r) begin
            sq_r    <= 1'b0;
            state_r <= ST_MUL;
          end else if (exp_r[EXP_W-1:1] == '0) begin
            // last bit consumed: the final squaring is never used
            state_r <= ST_IDLE;
          end else begin
            sq_r    <= 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (end_k) begin
            k_r <= '0;
            if (end_j) begin
              j_r <= '0;
              if (end_i) begin
                i_r     <= '0;
                state_r <= ST_MWAIT;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_MWAIT: begin
          if (acc_fin) state_r <= ST_COPY;
        end
        ST_COPY: begin
          if (end_j) begin
            j_r <= '0;
            if (end_i) begin
              i_r     <= '0;
              state_r <= ST_NEXT;
              if (sq_r) begin
                exp_r     <= exp_r >> 1;
                stepped_r <= 1'b0;
              end else begin
                stepped_r <= 1'b1;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_v_r <= 1'b0;
      mt_v_r   <= 1'b0;
      cp_v_r   <= 1'b0;
    end else begin
      init_v_r <= (state_r == ST_INIT);
      mt_v_r   <= (state_r == ST_MUL);
      cp_v_r   <= (state_r == ST_COPY);
    end
  end

  always_ff @(posedge clk) begin
    init_addr_r <= cur;
    cp_addr_r   <= cur;
    mt_tag_r    <= mt_tag;
  end

  mmp_modmul #(
    .TAG_W (TAG_W)
  ) u_modmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mt_v_r),
    .in_tag    (mt_tag_r),
    .in_a      (sq_r ? sqa_rd_r : res_rd_r),
    .in_b      (sqb_rd_r),
    .out_valid (mm_v),
    .out_tag   (mm_tag_bits),
    .out_res   (mm_res)
  );

  // accumulate the terms of one dot product
  always_comb begin
    mm_tag  = mm_tag_bits;
    acc_sum = (mm_tag.first ? '0 : {1'b0, acc_r}) + {1'b0, mm_res};
    acc_red = (acc_sum >= {1'b0, MODULUS}) ? VAL_W'(acc_sum - {1'b0, MODULUS})
                                           : VAL_W'(acc_sum);
    prd_we  = mm_v && mm_tag.last;
    acc_fin = mm_v && mm_tag.fin;
  end

  always_ff @(posedge clk) begin
    if (mm_v) acc_r <= acc_red;
  end

  // store port control
  always_comb begin
    base_we    = (state_r == ST_CLEAR) || req.wr;
    base_waddr = (state_r == ST_CLEAR) ? cur : req_addr;
    base_wdata = (state_r == ST_CLEAR) ? '0 : req.value;

    res_we = (state_r == ST_CLEAR) || (state_r == ST_INIT) || (cp_v_r && !sq_r);
    if (cp_v_r) begin
      res_waddr = cp_addr_r;
      res_wdata = prd_rd_r;
    end else begin
      res_waddr = cur;
      res_wdata = ((state_r == ST_INIT) && (i_r == j_r) && (DMW'(i_r) < dim_r))
                  ? VAL_W'(1) : '0;
    end
    res_re    = req.rd || ((state_r == ST_MUL) && !sq_r);
    res_raddr = req.rd ? req_addr : x_addr;

    sq_we    = init_v_r || (cp_v_r && sq_r);
    sq_waddr = init_v_r ? init_addr_r : cp_addr_r;
    sq_wdata = init_v_r ? base_rd_r : prd_rd_r;
  end

  always_ff @(posedge clk) begin
    if (base_we) base_mem[base_waddr] <= base_wdata;
    if (state_r == ST_INIT) base_rd_r <= base_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (res_re) res_rd_r <= res_mem[res_raddr];
  end

  always_ff @(posedge clk) begin
    if (sq_we) sq_mem[sq_waddr] <= sq_wdata;
    if ((state_r == ST_MUL) && sq_r) sqa_rd_r <= sq_mem[x_addr];
    if (state_r == ST_MUL) sqb_rd_r <= sq_mem[y_addr];
  end

  always_ff @(posedge clk) begin
    if (prd_we) prd_mem[mm_tag.dest] <= acc_red;
    if (state_r == ST_COPY) prd_rd_r <= prd_mem[cur];
  end

  assign busy  = (state_r != ST_IDLE);
  assign rdata = res_rd_r;

  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr || req.rd || req.run) |-> (state_r == ST_IDLE))
    else $error("request taken while sequencer busy");

  a_prd_window: assert property (@(posedge clk) disable iff (!rst_n)
    prd_we |-> (state_r == ST_MUL || state_r == ST_MWAIT))
    else $error("scratch write outside multiply pass");

  a_fin_wait: assert property (@(posedge clk) disable iff (!rst_n)
    acc_fin |-> (state_r == ST_MWAIT))
    else $error("last product arrived before issue finished");

  a_mul_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (exp_r != '0))
    else $error("multiply pass with exhausted exponent");

  a_copy_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY && $past(state_r) == ST_MWAIT) |-> $past(acc_fin))
    else $error("copy started before scratch complete");

endmodule

FILE: rtl/modular_matrix_power.sv
// Results: a write or read beat yields its result beat in the cycle after acceptance.
// Throughput: writes and reads take one beat per cycle unless the result slot is held by
// out_tready; a run beat is answered at once but holds the input through a base load and,
// per pass, a multiply sweep on the single multiplier and a copy-back sweep.
// Reset: synchronous, active low; a clearing pass zeroes every cell of the base and result
// stores, during which no beat is accepted.
// -----------------------------------------------------------------------------
// modular_matrix_power
// Square-and-multiply power of a residue matrix modulo 1000000007.
// -----------------------------------------------------------------------------
module modular_matrix_power import mmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // row_index[2:0], col_index[5:3], entry_value[35:6], exponent[98:36], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_value[29:0], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // read_valid[0]
  output logic                  out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [SIZE_W-1:0]     cfg_wr_data
);

  localparam int DMW = $clog2(MAX_DIM + 1);

  logic [SIZE_W-1:0] size_r;
  logic              ov_r, ov_read_r;
  logic [DMW-1:0]    dim;
  logic              busy, accept, in_store;
  logic [ROW_W-1:0]  row, col;
  logic [VAL_W-1:0]  value;
  logic [VAL_W-1:0]  rdata;
  mmp_req_t          req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(1);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (size_r == '0) begin
      dim = DMW'(1);
    end else if (int'(size_r) > MAX_DIM) begin
      dim = DMW'(MAX_DIM);
    end else begin
      dim = DMW'(size_r);
    end
  end

  assign in_tready = !busy && (!ov_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign row       = in_tdata[2:0];
  assign col       = in_tdata[5:3];
  assign in_store  = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  // reduce once on entry
  assign value     = (in_tdata[35:6] >= MODULUS) ? in_tdata[35:6] - MODULUS
                                                 : in_tdata[35:6];

  always_comb begin
    req.wr       = accept && (in_tuser == REQ_WRITE) && in_store;
    req.rd       = accept && (in_tuser == REQ_READ) && in_store;
    req.run      = accept && (in_tuser == REQ_RUN);
    req.row      = row;
    req.col      = col;
    req.value    = value;
    req.exponent = in_tdata[98:36];
  end

  mmp_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .dim   (dim),
    .busy  (busy),
    .rdata (rdata)
  );

  // one result slot; read data comes straight from the store's output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r      <= 1'b0;
      ov_read_r <= 1'b0;
    end else if (accept) begin
      ov_r      <= 1'b1;
      ov_read_r <= req.rd;
    end else if (out_tready) begin
      ov_r      <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {(OUT_DATA_W - VAL_W)'(0), ov_read_r ? rdata : '0};
  assign out_tuser  = ov_read_r;

endmodule
